// ----- rtl/core/bwc_pkg.sv -----
`default_nettype none

package bwc_pkg;

    // One input beat: a texel write or a bilinear lookup.
    typedef struct packed {
        logic               kind;
        logic [7:0]         texel_x;
        logic [6:0]         texel_y;
        logic [15:0]        red_in;
        logic [15:0]        green_in;
        logic [15:0]        blue_in;
        logic signed [23:0] u_coord;
        logic signed [23:0] v_coord;
    } in_item_t;

    // One result beat: the blended color.
    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
    } out_item_t;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;
    localparam int   CFG_DATA_W       = 9;

    localparam logic [8:0] IMAGE_WIDTH_RESET  = 9'd256;
    localparam logic [7:0] IMAGE_HEIGHT_RESET = 8'd128;

    // Texel centers sit half a texel in, and 1.0 in Q.16.
    localparam logic [15:0] HALF_Q16 = 16'h8000;
    localparam logic [16:0] ONE_Q16  = 17'h10000;

    localparam int TEXEL_W  = 48;
    localparam int WEIGHT_W = 33;

    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 4;

endpackage

`default_nettype wire

// ----- rtl/core/bwc_fifo.sv -----
`default_nettype none

module bwc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          pop,
    output logic      [W-1:0]  rdata,
    output logic               empty,
    output logic      [CW-1:0] count
);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bwc_front.sv -----
`default_nettype none

module bwc_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128,
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int HW  = $clog2(MAX_HEIGHT + 1),
    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int EW  = 2 + bwc_pkg::TEXEL_W + 4 * AW + 4 * bwc_pkg::WEIGHT_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire bwc_pkg::in_item_t item,
    input  wire logic [WW-1:0]    eff_w,
    input  wire logic [HW-1:0]    eff_h,
    output logic                  ent_valid,
    output logic      [EW-1:0]    ent_data,
    output logic      [1:0]       busy_cnt
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PUW = 16 + WW;
    localparam int PVW = 17 + HW;

    typedef struct packed {
        logic                             lookup;
        logic                             wr_en;
        logic [bwc_pkg::TEXEL_W-1:0]      texel;
        logic [AW-1:0]                    a00;
        logic [AW-1:0]                    a10;
        logic [AW-1:0]                    a01;
        logic [AW-1:0]                    a11;
        logic [bwc_pkg::WEIGHT_W-1:0]     k00;
        logic [bwc_pkg::WEIGHT_W-1:0]     k10;
        logic [bwc_pkg::WEIGHT_W-1:0]     k01;
        logic [bwc_pkg::WEIGHT_W-1:0]     k11;
    } ent_t;

    // Stage 1: scale the coordinates by the image size.
    logic                        f1_valid_reg;
    logic                        f1_lookup_reg;
    logic                        f1_wr_en_reg;
    logic [AW-1:0]               f1_addr_reg;
    logic [bwc_pkg::TEXEL_W-1:0] f1_texel_reg;
    logic [PUW-1:0]              f1_pu_reg;
    logic [PVW-1:0]              f1_pv_reg;

    // Stage 2: corner indices and fractional weights.
    logic                        f2_valid_reg;
    logic                        f2_lookup_reg;
    logic                        f2_wr_en_reg;
    logic [AW-1:0]               f2_addr_reg;
    logic [bwc_pkg::TEXEL_W-1:0] f2_texel_reg;
    logic [15:0]                 f2_tx_reg;
    logic [15:0]                 f2_ty_reg;
    logic [XW-1:0]               f2_x0_reg;
    logic [XW-1:0]               f2_x1_reg;
    logic [YW-1:0]               f2_y0_reg;
    logic [YW-1:0]               f2_y1_reg;

    // Stage 3: corner addresses and products of weights.
    logic                        f3_valid_reg;
    ent_t                        f3_ent_reg;

    logic [16:0]    vc;
    logic           wr_ok;
    logic [PUW-1:0] pu_next;
    logic [PVW-1:0] pv_next;
    logic [AW-1:0]  waddr_next;

    always_comb
    begin
        if (item.v_coord[23])
        begin
            vc = '0;
        end
        else if (item.v_coord > 24'sd65536)
        begin
            vc = bwc_pkg::ONE_Q16;
        end
        else
        begin
            vc = item.v_coord[16:0];
        end
        wr_ok      = (32'(item.texel_x) < MAX_WIDTH) && (32'(item.texel_y) < MAX_HEIGHT);
        pu_next    = PUW'(item.u_coord[15:0]) * PUW'(eff_w);
        pv_next    = PVW'(vc) * PVW'(eff_h);
        waddr_next = AW'(32'(item.texel_y) * MAX_WIDTH + 32'(item.texel_x));
    end

    logic           x_neg;
    logic [PUW-1:0] dx;
    logic [WW-1:0]  x0p;
    logic [WW-1:0]  x0p_inc;
    logic           y_neg;
    logic [PVW-1:0] dy;
    logic [HW:0]    y0p;
    logic [HW:0]    y0p_inc;
    logic [XW-1:0]  x0_next;
    logic [XW-1:0]  x1_next;
    logic [YW-1:0]  y0_next;
    logic [YW-1:0]  y1_next;

    always_comb
    begin
        x_neg   = (f1_pu_reg < PUW'(bwc_pkg::HALF_Q16));
        dx      = f1_pu_reg - PUW'(bwc_pkg::HALF_Q16);
        x0p     = dx[PUW-1:16];
        x0p_inc = x0p + 1'b1;
        y_neg   = (f1_pv_reg < PVW'(bwc_pkg::HALF_Q16));
        dy      = f1_pv_reg - PVW'(bwc_pkg::HALF_Q16);
        y0p     = dy[PVW-1:16];
        y0p_inc = y0p + 1'b1;
        // The column left of the first one wraps to the last column.
        if (x_neg)
        begin
            x0_next = XW'(eff_w - 1'b1);
            x1_next = '0;
        end
        else
        begin
            x0_next = XW'(x0p);
            x1_next = (x0p_inc == eff_w) ? '0 : XW'(x0p_inc);
        end
        // Rows above the top or below the bottom clamp to the edge row.
        if (y_neg)
        begin
            y0_next = '0;
            y1_next = '0;
        end
        else
        begin
            y0_next = YW'(y0p);
            y1_next = (y0p_inc >= {1'b0, eff_h}) ? YW'(eff_h - 1'b1) : YW'(y0p_inc);
        end
    end

    logic [16:0] wx0;
    logic [16:0] wx1;
    logic [16:0] wy0;
    logic [16:0] wy1;
    ent_t        ent_next;

    always_comb
    begin
        wx0 = bwc_pkg::ONE_Q16 - 17'(f2_tx_reg);
        wx1 = 17'(f2_tx_reg);
        wy0 = bwc_pkg::ONE_Q16 - 17'(f2_ty_reg);
        wy1 = 17'(f2_ty_reg);
        ent_next.lookup = f2_lookup_reg;
        ent_next.wr_en  = f2_wr_en_reg;
        ent_next.texel  = f2_texel_reg;
        ent_next.k00    = bwc_pkg::WEIGHT_W'(34'(wx0) * 34'(wy0));
        ent_next.k10    = bwc_pkg::WEIGHT_W'(34'(wx1) * 34'(wy0));
        ent_next.k01    = bwc_pkg::WEIGHT_W'(34'(wx0) * 34'(wy1));
        ent_next.k11    = bwc_pkg::WEIGHT_W'(34'(wx1) * 34'(wy1));
        if (f2_lookup_reg)
        begin
            ent_next.a00 = AW'(32'(f2_y0_reg) * MAX_WIDTH + 32'(f2_x0_reg));
        end
        else
        begin
            ent_next.a00 = f2_addr_reg;
        end
        ent_next.a10 = AW'(32'(f2_y0_reg) * MAX_WIDTH + 32'(f2_x1_reg));
        ent_next.a01 = AW'(32'(f2_y1_reg) * MAX_WIDTH + 32'(f2_x0_reg));
        ent_next.a11 = AW'(32'(f2_y1_reg) * MAX_WIDTH + 32'(f2_x1_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_lookup_reg <= (item.kind == bwc_pkg::KIND_LOOKUP);
        f1_wr_en_reg  <= (item.kind == bwc_pkg::KIND_WRITE) && wr_ok;
        f1_addr_reg   <= waddr_next;
        f1_texel_reg  <= {item.red_in, item.green_in, item.blue_in};
        f1_pu_reg     <= pu_next;
        f1_pv_reg     <= pv_next;

        f2_lookup_reg <= f1_lookup_reg;
        f2_wr_en_reg  <= f1_wr_en_reg;
        f2_addr_reg   <= f1_addr_reg;
        f2_texel_reg  <= f1_texel_reg;
        f2_tx_reg     <= f1_pu_reg[15:0] ^ bwc_pkg::HALF_Q16;
        f2_ty_reg     <= f1_pv_reg[15:0] ^ bwc_pkg::HALF_Q16;
        f2_x0_reg     <= x0_next;
        f2_x1_reg     <= x1_next;
        f2_y0_reg     <= y0_next;
        f2_y1_reg     <= y1_next;

        f3_ent_reg    <= ent_next;
    end

    assign ent_valid = f3_valid_reg;
    assign ent_data  = f3_ent_reg;
    assign busy_cnt  = {1'b0, f1_valid_reg} + {1'b0, f2_valid_reg} + {1'b0, f3_valid_reg};

endmodule

`default_nettype wire

// ----- rtl/core/bwc_back.sv -----
`default_nettype none

module bwc_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128,
    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int EW  = 2 + bwc_pkg::TEXEL_W + 4 * AW + 4 * bwc_pkg::WEIGHT_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mid_empty,
    input  wire logic [EW-1:0]      mid_data,
    output logic                    mid_pop,
    input  wire logic               pop,
    output logic                    empty,
    output bwc_pkg::out_item_t      result
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PW    = 16 + bwc_pkg::WEIGHT_W;
    localparam int SW    = PW + 2;
    localparam int OCW   = $clog2(bwc_pkg::OUT_DEPTH + 1);

    typedef struct packed {
        logic                             lookup;
        logic                             wr_en;
        logic [bwc_pkg::TEXEL_W-1:0]      texel;
        logic [AW-1:0]                    a00;
        logic [AW-1:0]                    a10;
        logic [AW-1:0]                    a01;
        logic [AW-1:0]                    a11;
        logic [bwc_pkg::WEIGHT_W-1:0]     k00;
        logic [bwc_pkg::WEIGHT_W-1:0]     k10;
        logic [bwc_pkg::WEIGHT_W-1:0]     k01;
        logic [bwc_pkg::WEIGHT_W-1:0]     k11;
    } ent_t;

    ent_t ent;
    assign ent = mid_data;

    // Two copies of the store so that four corners are read per cycle.
    logic [bwc_pkg::TEXEL_W-1:0] mem_top [DEPTH];
    logic [bwc_pkg::TEXEL_W-1:0] mem_bot [DEPTH];

    logic                         b1_valid_reg;
    logic [bwc_pkg::TEXEL_W-1:0]  b1_t00_reg;
    logic [bwc_pkg::TEXEL_W-1:0]  b1_t10_reg;
    logic [bwc_pkg::TEXEL_W-1:0]  b1_t01_reg;
    logic [bwc_pkg::TEXEL_W-1:0]  b1_t11_reg;
    logic [bwc_pkg::WEIGHT_W-1:0] b1_k00_reg;
    logic [bwc_pkg::WEIGHT_W-1:0] b1_k10_reg;
    logic [bwc_pkg::WEIGHT_W-1:0] b1_k01_reg;
    logic [bwc_pkg::WEIGHT_W-1:0] b1_k11_reg;

    logic          b2_valid_reg;
    logic [PW-1:0] b2_prod_reg [3][4];

    logic [OCW-1:0] out_count;
    logic [OCW:0]   pending;

    assign pending = {1'b0, out_count} + (OCW + 1)'(b1_valid_reg) + (OCW + 1)'(b2_valid_reg);
    assign mid_pop = !mid_empty && (pending < (OCW + 1)'(bwc_pkg::OUT_DEPTH));

    always_ff @(posedge clk)
    begin
        if (mid_pop && ent.wr_en)
        begin
            mem_top[ent.a00] <= ent.texel;
            mem_bot[ent.a00] <= ent.texel;
        end
        if (mid_pop)
        begin
            b1_t00_reg <= mem_top[ent.a00];
            b1_t10_reg <= mem_top[ent.a10];
            b1_t01_reg <= mem_bot[ent.a01];
            b1_t11_reg <= mem_bot[ent.a11];
            b1_k00_reg <= ent.k00;
            b1_k10_reg <= ent.k10;
            b1_k01_reg <= ent.k01;
            b1_k11_reg <= ent.k11;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= mid_pop && ent.lookup;
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            b2_prod_reg[c][0] <= PW'(b1_t00_reg[c*16 +: 16]) * PW'(b1_k00_reg);
            b2_prod_reg[c][1] <= PW'(b1_t10_reg[c*16 +: 16]) * PW'(b1_k10_reg);
            b2_prod_reg[c][2] <= PW'(b1_t01_reg[c*16 +: 16]) * PW'(b1_k01_reg);
            b2_prod_reg[c][3] <= PW'(b1_t11_reg[c*16 +: 16]) * PW'(b1_k11_reg);
        end
    end

    logic [SW-1:0]  sum  [3];
    logic [47:0]    blend;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = SW'(b2_prod_reg[c][0]) + SW'(b2_prod_reg[c][1])
                   + SW'(b2_prod_reg[c][2]) + SW'(b2_prod_reg[c][3])
                   + SW'(33'h080000000);
            if (|sum[c][SW-1:48])
            begin
                blend[c*16 +: 16] = 16'hFFFF;
            end
            else
            begin
                blend[c*16 +: 16] = sum[c][47:32];
            end
        end
    end

    logic [47:0] out_raw;

    bwc_fifo #(
        .W     (48),
        .DEPTH (bwc_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b2_valid_reg),
        .wdata (blend),
        .pop   (pop && !empty),
        .rdata (out_raw),
        .empty (empty),
        .count (out_count)
    );

    assign result = out_raw;

endmodule

`default_nettype wire

// ----- rtl/core/bilinear_wrap_clamp_texel_fetch.sv -----
// A lookup beat passes f1, f2, f3, the middle queue, b1, b2 and the output queue.
// Throughput: one beat per cycle while full is low, writes and lookups alike; two
// texel store copies, each with two read ports, read all four corners together.
// Reset: rst_n clears all control state and sets image_width to 256 and
// image_height to 128; texel storage is not cleared and is undefined until written.
`default_nettype none

module bilinear_wrap_clamp_texel_fetch #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire bwc_pkg::in_item_t            item,
    output logic                              empty,
    input  wire logic                         pop,
    output bwc_pkg::out_item_t                result,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [bwc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int EW  = 2 + bwc_pkg::TEXEL_W + 4 * AW + 4 * bwc_pkg::WEIGHT_W;
    localparam int MCW = $clog2(bwc_pkg::MID_DEPTH + 1);

    // Configuration registers. The user must write them only while idle; the
    // block does not enforce it, so items in flight may read them directly.
    logic [8:0] image_width_reg;
    logic [7:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bwc_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= bwc_pkg::IMAGE_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bwc_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                bwc_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // A size of zero behaves as one, and a size beyond the store behaves as
    // the store's own size.
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(image_width_reg);
        end
        if (image_height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (32'(image_height_reg) > MAX_HEIGHT)
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(image_height_reg);
        end
    end

    // The front end turns each beat into store addresses and corner weights
    // over three stages that never stall. Back pressure is handled by credit:
    // a beat is taken only while the middle queue has room for everything
    // already in the front end plus the new beat.
    logic           accept;
    logic           ent_valid;
    logic [EW-1:0]  ent_data;
    logic [1:0]     front_cnt;
    logic [EW-1:0]  mid_data;
    logic           mid_empty;
    logic           mid_pop;
    logic [MCW-1:0] mid_count;
    logic [MCW:0]   committed;

    assign committed = {1'b0, mid_count} + (MCW + 1)'(front_cnt);
    assign full      = (committed >= (MCW + 1)'(bwc_pkg::MID_DEPTH));
    assign accept    = push && !full;

    bwc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .ent_valid (ent_valid),
        .ent_data  (ent_data),
        .busy_cnt  (front_cnt)
    );

    // The middle queue decouples address work from store access, so a stalled
    // result side does not hold up the front end until the queue fills.
    bwc_fifo #(
        .W     (EW),
        .DEPTH (bwc_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ent_valid),
        .wdata (ent_data),
        .pop   (mid_pop),
        .rdata (mid_data),
        .empty (mid_empty),
        .count (mid_count)
    );

    // The back end performs writes and reads in queue order, so a lookup always
    // sees every texel written by earlier beats. It blends, rounds and saturates
    // and holds results in its own output queue.
    bwc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_data  (mid_data),
        .mid_pop   (mid_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // The credit scheme must keep the middle queue from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ent_valid && !mid_pop) |-> (mid_count < MCW'(bwc_pkg::MID_DEPTH)))
        else $error("middle queue overflow");

    // An accepted beat must occupy the front end on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (front_cnt != 2'd0))
        else $error("accepted beat lost in front end");

    // The back end only drains the middle queue when it holds something.
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> (mid_count != '0))
        else $error("pop from empty middle queue");

endmodule

`default_nettype wire
